/* rtl/core/hgs_pkg.sv */
`timescale 1ns / 1ps

package hgs_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_SAMPLE_BITS = 24;

  localparam int DIFF_W  = MAX_SAMPLE_BITS + 1;
  localparam int INV_W   = 16;
  localparam int PROD_W  = DIFF_W + INV_W + 1;
  localparam int GRAD_W  = 24;
  localparam int SQ_W    = 2 * GRAD_W;
  localparam int ROOT_W  = 24;
  localparam int REM_W   = ROOT_W + 2;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 16;
  localparam int GCOL_W  = 11;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = 16;
  localparam int QDEPTH  = 4;

  localparam logic [IDX_W-1:0] REG_GRID_COLUMNS  = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_ROWS     = 2'd1;
  localparam logic [IDX_W-1:0] REG_INV_SPACING_X = 2'd2;
  localparam logic [IDX_W-1:0] REG_INV_SPACING_Y = 2'd3;

  localparam logic [GCOL_W-1:0] GRID_COLUMNS_RST = 11'd1024;
  localparam logic [ROW_W-1:0]  GRID_ROWS_RST    = 16'd1024;
  localparam logic [INV_W-1:0]  INV_SPACING_RST  = 16'd256;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef struct packed {
    diff_t             diff_x;
    diff_t             diff_y;
    logic              central_x;
    logic              central_y;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_RD0,
    F_RD1,
    F_RD2,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SAT,
    B_SQ,
    B_SUM,
    B_ROOT,
    B_OUT
  } back_state_t;

  function automatic grad_t sat_grad(input prod_t v);
    prod_t hi;
    prod_t lo;
    grad_t res;
    hi = prod_t'(signed'({1'b0, {(GRAD_W-1){1'b1}}}));
    lo = -hi - prod_t'(1);
    if (v > hi) begin
      res = grad_t'(hi);
    end else if (v < lo) begin
      res = grad_t'(lo);
    end else begin
      res = grad_t'(v);
    end
    return res;
  endfunction

endpackage

/* rtl/core/hgs_if.sv */
`timescale 1ns / 1ps

interface hgs_in_if #(
  parameter int SAMPLE_BITS = hgs_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink (input valid, input height_sample, output ready);
endinterface

interface hgs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [hgs_pkg::GRAD_W-1:0] grad_x;
  logic signed [hgs_pkg::GRAD_W-1:0] grad_y;
  logic [hgs_pkg::ROOT_W-1:0]       slope_mag;
  logic [hgs_pkg::COL_W-1:0]        cell_col;
  logic [hgs_pkg::ROW_W-1:0]        cell_row;
  logic                             last_of_run;

  modport source (output valid, output grad_x, output grad_y, output slope_mag,
                  output cell_col, output cell_row, output last_of_run, input ready);
  modport sink (input valid, input grad_x, input grad_y, input slope_mag,
                input cell_col, input cell_row, input last_of_run, output ready);
endinterface

interface hgs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hgs_pkg::IDX_W-1:0]  index;
  logic [hgs_pkg::DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/heightfield_gradient_slope.sv */
`timescale 1ns / 1ps
// flow: the front end takes a sample only when idle and finishes it before taking the next:
//   store reads in F_RD0, F_RD1 and F_RD2, then one queue push per result in F_PUSH
//   (stalled while the queue is full) and a close back to idle; the back end pops one job
//   at a time and runs it to output; sustained rate is set by the back end
// reset: synchronous active-low; counters, window and config return to defaults,
//   row stores are not cleared

module heightfield_gradient_slope #(
  parameter int MAX_COLUMNS = hgs_pkg::MAX_COLUMNS_DEF,
  parameter int SAMPLE_BITS = hgs_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hgs_in_if.sink     in_chan,
  hgs_out_if.source  out_chan,
  hgs_cfg_if.sink    cfg_chan
);
  import hgs_pkg::*;

  logic [GCOL_W-1:0] grid_columns_r;
  logic [ROW_W-1:0]  grid_rows_r;
  logic [INV_W-1:0]  inv_spacing_x_r;
  logic [INV_W-1:0]  inv_spacing_y_r;

  logic push, full, pop, empty;
  job_t job_in, job_out;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r  <= GRID_COLUMNS_RST;
      grid_rows_r     <= GRID_ROWS_RST;
      inv_spacing_x_r <= INV_SPACING_RST;
      inv_spacing_y_r <= INV_SPACING_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        REG_GRID_COLUMNS:  grid_columns_r  <= cfg_chan.data[GCOL_W-1:0];
        REG_GRID_ROWS:     grid_rows_r     <= cfg_chan.data;
        REG_INV_SPACING_X: inv_spacing_x_r <= cfg_chan.data;
        REG_INV_SPACING_Y: inv_spacing_y_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  hgs_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .grid_columns (grid_columns_r),
    .grid_rows    (grid_rows_r),
    .full_i       (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  hgs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  hgs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty_i       (empty),
    .job_i         (job_out),
    .pop_o         (pop),
    .inv_spacing_x (inv_spacing_x_r),
    .inv_spacing_y (inv_spacing_y_r),
    .out_chan      (out_chan)
  );

endmodule

/* rtl/core/hgs_front.sv */
`timescale 1ns / 1ps

module hgs_front #(
  parameter int MAX_COLUMNS = hgs_pkg::MAX_COLUMNS_DEF,
  parameter int SAMPLE_BITS = hgs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hgs_in_if.sink                      in_chan,
  input  logic [hgs_pkg::GCOL_W-1:0]  grid_columns,
  input  logic [hgs_pkg::ROW_W-1:0]   grid_rows,
  input  logic                        full_i,
  output logic                        push_o,
  output hgs_pkg::job_t               job_o
);
  import hgs_pkg::*;

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int WW = (AW + 1 > GCOL_W) ? AW + 1 : GCOL_W;

  front_state_t st_r, st_nxt;

  logic signed [SAMPLE_BITS-1:0] newer_mem [MAX_COLUMNS];
  logic signed [SAMPLE_BITS-1:0] older_mem [MAX_COLUMNS];
  logic signed [SAMPLE_BITS-1:0] newer_q, older_q;
  logic [AW-1:0]                 n_ra, o_ra;
  logic                          mem_we;

  logic signed [SAMPLE_BITS-1:0] x_r, nc_r, oc_r, w0_r, w1_r;
  logic [AW-1:0]                 c_r;
  logic [ROW_W-1:0]              r_r;
  job_t                          job_a_r, job_b_r, job_c_r;
  logic [2:0]                    pend_r;
  logic                          accept;

  logic [WW-1:0]    gc_ext, wcl, wlast;
  logic [ROW_W-1:0] hcl;
  logic             at_end, last_row;
  diff_t            xe, nce, oce, nne, ome, w0e, w1e;
  job_t             ja, jb, jc;
  logic             has_a, has_b, has_c;

  assign in_chan.ready = (st_r == F_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // frame geometry
  always_comb begin
    gc_ext = WW'(grid_columns);
    if (gc_ext < WW'(2)) begin
      wcl = WW'(2);
    end else if (gc_ext > WW'(MAX_COLUMNS)) begin
      wcl = WW'(MAX_COLUMNS);
    end else begin
      wcl = gc_ext;
    end
    wlast    = wcl - WW'(1);
    hcl      = (grid_rows < ROW_W'(2)) ? ROW_W'(2) : grid_rows;
    at_end   = WW'(c_r) >= wlast;
    last_row = r_r >= (hcl - ROW_W'(1));
  end

  // row stores
  assign n_ra   = (st_r == F_RD1) ? c_r + AW'(1) : c_r;
  assign o_ra   = (st_r == F_RD1) ? c_r - AW'(1) : c_r;
  assign mem_we = (st_r == F_RD2);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      newer_mem[c_r] <= x_r;
      older_mem[c_r] <= nc_r;
    end
    newer_q <= newer_mem[n_ra];
    older_q <= older_mem[o_ra];
  end

  // cell classification
  always_comb begin
    xe  = diff_t'(x_r);
    nce = diff_t'(nc_r);
    oce = diff_t'(oc_r);
    nne = diff_t'(newer_q);
    ome = diff_t'(older_q);
    w0e = diff_t'(w0_r);
    w1e = diff_t'(w1_r);

    has_a = (r_r != '0);
    has_b = last_row && (c_r != '0);
    has_c = last_row && at_end;

    ja = '0;
    if (c_r == '0) begin
      ja.diff_x    = nne - nce;
      ja.central_x = 1'b0;
    end else if (at_end) begin
      ja.diff_x    = nce - ome;
      ja.central_x = 1'b0;
    end else begin
      ja.diff_x    = nne - ome;
      ja.central_x = 1'b1;
    end
    if (r_r == ROW_W'(1)) begin
      ja.diff_y    = xe - nce;
      ja.central_y = 1'b0;
    end else begin
      ja.diff_y    = xe - oce;
      ja.central_y = 1'b1;
    end
    ja.col  = COL_W'(c_r);
    ja.row  = r_r - ROW_W'(1);
    ja.last = !has_b && !has_c;

    jb = '0;
    if (c_r == AW'(1)) begin
      jb.diff_x    = xe - w0e;
      jb.central_x = 1'b0;
    end else begin
      jb.diff_x    = xe - w1e;
      jb.central_x = 1'b1;
    end
    jb.diff_y    = w0e - ome;
    jb.central_y = 1'b0;
    jb.col       = COL_W'(c_r - AW'(1));
    jb.row       = r_r;
    jb.last      = !has_c;

    jc           = '0;
    jc.diff_x    = xe - w0e;
    jc.diff_y    = xe - nce;
    jc.central_x = 1'b0;
    jc.central_y = 1'b0;
    jc.col       = COL_W'(c_r);
    jc.row       = r_r;
    jc.last      = 1'b1;
  end

  always_comb begin
    st_nxt = st_r;
    push_o = 1'b0;
    job_o  = job_c_r;
    if (pend_r[0]) begin
      job_o = job_a_r;
    end else if (pend_r[1]) begin
      job_o = job_b_r;
    end
    unique case (st_r)
      F_IDLE: if (accept) st_nxt = F_RD0;
      F_RD0:  st_nxt = F_RD1;
      F_RD1:  st_nxt = F_RD2;
      F_RD2:  st_nxt = F_PUSH;
      F_PUSH: begin
        if (pend_r == '0) begin
          st_nxt = F_IDLE;
        end else begin
          push_o = !full_i;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      c_r    <= '0;
      r_r    <= '0;
      w0_r   <= '0;
      w1_r   <= '0;
      pend_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == F_RD2) begin
        pend_r <= {has_c, has_b, has_a};
      end else if (push_o) begin
        if (pend_r[0]) begin
          pend_r[0] <= 1'b0;
        end else if (pend_r[1]) begin
          pend_r[1] <= 1'b0;
        end else begin
          pend_r[2] <= 1'b0;
        end
      end
      if (st_r == F_PUSH && pend_r == '0) begin
        w1_r <= w0_r;
        w0_r <= x_r;
        if (at_end) begin
          c_r <= '0;
          r_r <= last_row ? '0 : r_r + ROW_W'(1);
        end else begin
          c_r <= c_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_chan.height_sample;
    end
    if (st_r == F_RD1) begin
      nc_r <= newer_q;
      oc_r <= older_q;
    end
    if (st_r == F_RD2) begin
      job_a_r <= ja;
      job_b_r <= jb;
      job_c_r <= jc;
    end
  end

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> st_r == F_RD0)
    else $error("front did not start store reads after a transaction");
  a_push_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    push_o |-> (st_r == F_PUSH) && (pend_r != '0) && !full_i)
    else $error("front pushed without a pending cell");
`endif

endmodule

/* rtl/core/hgs_queue.sv */
`timescale 1ns / 1ps

module hgs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  hgs_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output hgs_pkg::job_t job_o
);
  import hgs_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  job_t           q_mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full_o  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_r == '0);
  assign job_o   = q_mem[rp_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_mem[wp_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) wp_r <= wp_r + QAW'(1);
      if (pop_i)  rp_r <= rp_r + QAW'(1);
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o || pop_i)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/core/hgs_back.sv */
`timescale 1ns / 1ps

module hgs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       empty_i,
  input  hgs_pkg::job_t              job_i,
  output logic                       pop_o,
  input  logic [hgs_pkg::INV_W-1:0]  inv_spacing_x,
  input  logic [hgs_pkg::INV_W-1:0]  inv_spacing_y,
  hgs_out_if.source                  out_chan
);
  import hgs_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  back_state_t st_r, st_nxt;

  job_t                      job_r;
  prod_t                     px_r, py_r;
  grad_t                     gx_r, gy_r;
  logic [SQ_W-1:0]           sqx_r, sqy_r, num_r;
  logic [REM_W-1:0]          rem_r;
  logic [ROOT_W-1:0]         root_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      load_out;
  logic                      ov_r;
  logic signed [SQ_W-1:0]    gxe, gye;
  logic [REM_W+1:0]          rem_t, cand;

  assign gxe = SQ_W'(gx_r);
  assign gye = SQ_W'(gy_r);

  // one root bit per step
  assign rem_t = {rem_r, num_r[SQ_W-1 -: 2]};
  assign cand  = {2'b00, root_r, 2'b01};

  always_comb begin
    st_nxt   = st_r;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          st_nxt = B_MUL;
        end
      end
      B_MUL:  st_nxt = B_SAT;
      B_SAT:  st_nxt = B_SQ;
      B_SQ:   st_nxt = B_SUM;
      B_SUM:  st_nxt = B_ROOT;
      B_ROOT: if (cnt_r == CNT_W'(ROOT_W - 1)) st_nxt = B_OUT;
      B_OUT: begin
        if (!ov_r || out_chan.ready) begin
          load_out = 1'b1;
          st_nxt   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      job_r <= job_i;
    end
    if (st_r == B_MUL) begin
      px_r <= $signed(job_r.diff_x) * $signed({1'b0, inv_spacing_x});
      py_r <= $signed(job_r.diff_y) * $signed({1'b0, inv_spacing_y});
    end
    if (st_r == B_SAT) begin
      gx_r <= sat_grad(job_r.central_x ? (px_r >>> 9) : (px_r >>> 8));
      gy_r <= sat_grad(job_r.central_y ? (py_r >>> 9) : (py_r >>> 8));
    end
    if (st_r == B_SQ) begin
      sqx_r <= gxe * gxe;
      sqy_r <= gye * gye;
    end
    if (st_r == B_SUM) begin
      num_r  <= sqx_r + sqy_r;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end
    if (st_r == B_ROOT) begin
      num_r <= num_r << 2;
      cnt_r <= cnt_r + CNT_W'(1);
      if (rem_t >= cand) begin
        rem_r  <= REM_W'(rem_t - cand);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(rem_t);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (load_out) begin
      out_chan.grad_x      <= gx_r;
      out_chan.grad_y      <= gy_r;
      out_chan.slope_mag   <= root_r;
      out_chan.cell_col    <= job_r.col;
      out_chan.cell_row    <= job_r.row;
      out_chan.last_of_run <= job_r.last;
    end
  end

  assign out_chan.valid = ov_r;

`ifndef SYNTHESIS
  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_ROOT && cnt_r == CNT_W'(ROOT_W - 1)) |=> st_r == B_OUT)
    else $error("root iteration count wrong");
`endif

endmodule

/* verif/tb_heightfield_gradient_slope.sv */
`timescale 1ns / 1ps

module tb_heightfield_gradient_slope;
  import hgs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 110;

  typedef struct {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [ROOT_W-1:0]        slope_mag;
    logic [COL_W-1:0]         cell_col;
    logic [ROW_W-1:0]         cell_row;
    logic                     last_of_run;
  } slope_result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    int               value;
    bit               chk;
    int               gx;
    int               gy;
    int               mag;
  } dir_row_t;

  logic clk;
  logic rst_n;
  int   cycles;
  int   fails;
  int   hold_cycles;
  bit   idle_mode;

  hgs_in_if #(.SAMPLE_BITS(16)) in_if();
  hgs_out_if out_if();
  hgs_cfg_if cfg_if();

  heightfield_gradient_slope uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  // heightfield state mirrored from the block
  int older_hts [MAX_COLUMNS_DEF];
  int newer_hts [MAX_COLUMNS_DEF];
  int win_prev1;
  int win_prev2;
  int unsigned col_cnt;
  int unsigned row_cnt;
  logic [GCOL_W-1:0] cols_reg;
  logic [ROW_W-1:0]  rows_reg;
  logic [INV_W-1:0]  inv_x_reg;
  logic [INV_W-1:0]  inv_y_reg;

  slope_result_t pending_slopes [$];

  dir_row_t dir_tbl [36] = '{
    '{ROW_CFG, REG_GRID_COLUMNS, 3, 0, 0, 0, 0},
    '{ROW_CFG, REG_GRID_ROWS, 3, 0, 0, 0, 0},
    '{ROW_CFG, REG_INV_SPACING_X, 256, 0, 0, 0, 0},
    '{ROW_CFG, REG_INV_SPACING_Y, 256, 0, 0, 0, 0},
    // flat zero frame
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 1, 0, 0, 0},
    // extremes
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 32767, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, -32768, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 32767, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, -32768, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 32767, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, -32768, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, -1, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 1, 0, 0, 0, 0},
    // zero spacing gives zero gradients
    '{ROW_CFG, REG_GRID_COLUMNS, 2, 0, 0, 0, 0},
    '{ROW_CFG, REG_GRID_ROWS, 2, 0, 0, 0, 0},
    '{ROW_CFG, REG_INV_SPACING_X, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_INV_SPACING_Y, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 32767, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, -32768, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, -1, 1, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 1, 1, 0, 0, 0},
    // saturation
    '{ROW_CFG, REG_INV_SPACING_X, 65535, 0, 0, 0, 0},
    '{ROW_CFG, REG_INV_SPACING_Y, 65535, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 32767, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, -32768, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, -32768, 0, 0, 0, 0},
    '{ROW_SAMPLE, REG_GRID_COLUMNS, 32767, 0, 0, 0, 0}
  };

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [GRAD_W-1:0] scaled_grad(longint d, int unsigned inv,
                                                            bit central);
    longint v;
    v = (d * longint'(inv)) >>> (central ? 9 : 8);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[GRAD_W-1:0];
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void push_cell(logic signed [GRAD_W-1:0] gx,
                                    logic signed [GRAD_W-1:0] gy,
                                    int unsigned col, int unsigned row);
    slope_result_t res;
    longint sx;
    longint sy;
    longint unsigned m;
    sx = gx;
    sy = gy;
    m = floor_root(longint'(sx * sx) + longint'(sy * sy));
    if (m > 64'd16777215) m = 64'd16777215;
    res.grad_x = gx;
    res.grad_y = gy;
    res.slope_mag = m[ROOT_W-1:0];
    res.cell_col = col[COL_W-1:0];
    res.cell_row = row[ROW_W-1:0];
    res.last_of_run = 1'b0;
    pending_slopes.insert(pending_slopes.size(), res);
  endfunction

  // returns the number of cells completed by this height
  function automatic int advance_heightfield(logic signed [15:0] h);
    int unsigned w;
    int unsigned hh;
    int unsigned c;
    int unsigned r;
    int x;
    int n;
    bit last_row;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    w = cols_reg;
    hh = rows_reg;
    c = col_cnt;
    r = row_cnt;
    x = h;
    n = 0;
    if (w < 2) w = 2;
    if (w > MAX_COLUMNS_DEF) w = MAX_COLUMNS_DEF;
    if (hh < 2) hh = 2;
    if (c >= MAX_COLUMNS_DEF) c = MAX_COLUMNS_DEF - 1;
    last_row = (r >= hh - 1);
    if (r >= 1) begin
      if (c == 0) gx = scaled_grad(newer_hts[1] - newer_hts[0], inv_x_reg, 0);
      else if (c >= w - 1) gx = scaled_grad(newer_hts[c] - older_hts[c-1], inv_x_reg, 0);
      else gx = scaled_grad(newer_hts[c+1] - older_hts[c-1], inv_x_reg, 1);
      if (r == 1) gy = scaled_grad(x - newer_hts[c], inv_y_reg, 0);
      else gy = scaled_grad(x - older_hts[c], inv_y_reg, 1);
      push_cell(gx, gy, c, r - 1);
      n++;
    end
    if (last_row && c >= 1) begin
      if (c == 1) gx = scaled_grad(x - win_prev1, inv_x_reg, 0);
      else gx = scaled_grad(x - win_prev2, inv_x_reg, 1);
      gy = scaled_grad(win_prev1 - older_hts[c-1], inv_y_reg, 0);
      push_cell(gx, gy, c - 1, r);
      n++;
    end
    if (last_row && c >= w - 1) begin
      gx = scaled_grad(x - win_prev1, inv_x_reg, 0);
      gy = scaled_grad(x - newer_hts[c], inv_y_reg, 0);
      push_cell(gx, gy, c, r);
      n++;
    end
    if (n > 0) pending_slopes[pending_slopes.size()-1].last_of_run = 1'b1;
    older_hts[c] = newer_hts[c];
    newer_hts[c] = x;
    win_prev2 = win_prev1;
    win_prev1 = x;
    if (c >= w - 1) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      col_cnt = c + 1;
    end
    return n;
  endfunction

  task automatic drain_results();
    while (pending_slopes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_GRID_COLUMNS: cols_reg = data[GCOL_W-1:0];
      REG_GRID_ROWS: rows_reg = data;
      REG_INV_SPACING_X: inv_x_reg = data;
      REG_INV_SPACING_Y: inv_y_reg = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_height(logic signed [15:0] h, output int n);
    int gap;
    gap = 0;
    if (idle_mode && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.height_sample <= h;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n = advance_heightfield(h);
  endtask

  // receiver side
  int rx_gap;
  initial out_if.ready = 1'b0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_gap > 0) begin
      out_if.ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (idle_mode && $urandom_range(0, 3) == 0)
        rx_gap <= ($urandom_range(0, 11) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    slope_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_slopes.size() == 0) begin
        $error("unexpected result transaction col %0d row %0d", out_if.cell_col,
               out_if.cell_row);
        fails++;
      end else begin
        want = pending_slopes.pop_front();
        if (out_if.grad_x !== want.grad_x) begin
          $error("grad_x expected %0d actual %0d", want.grad_x, out_if.grad_x);
          fails++;
        end
        if (out_if.grad_y !== want.grad_y) begin
          $error("grad_y expected %0d actual %0d", want.grad_y, out_if.grad_y);
          fails++;
        end
        if (out_if.slope_mag !== want.slope_mag) begin
          $error("slope_mag expected %0d actual %0d", want.slope_mag, out_if.slope_mag);
          fails++;
        end
        if (out_if.cell_col !== want.cell_col) begin
          $error("cell_col expected %0d actual %0d", want.cell_col, out_if.cell_col);
          fails++;
        end
        if (out_if.cell_row !== want.cell_row) begin
          $error("cell_row expected %0d actual %0d", want.cell_row, out_if.cell_row);
          fails++;
        end
        if (out_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %0d actual %0d", want.last_of_run,
                 out_if.last_of_run);
          fails++;
        end
      end
    end
  end

  initial begin
    int n;
    int sent;
    int unsigned cols_val;
    int unsigned rows_val;
    int unsigned w_eff;
    int unsigned h_eff;
    int frames;
    bit smooth;
    logic signed [15:0] h;
    cycles = 0;
    fails = 0;
    hold_cycles = 0;
    rx_gap = 0;
    idle_mode = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.height_sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_GRID_COLUMNS;
    cfg_if.data = '0;
    col_cnt = 0;
    row_cnt = 0;
    win_prev1 = 0;
    win_prev2 = 0;
    cols_reg = GRID_COLUMNS_RST;
    rows_reg = GRID_ROWS_RST;
    inv_x_reg = INV_SPACING_RST;
    inv_y_reg = INV_SPACING_RST;
    foreach (older_hts[i]) begin
      older_hts[i] = 0;
      newer_hts[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        in_if.valid <= 1'b0;
        drain_results();
        write_reg(dir_tbl[i].idx, dir_tbl[i].value[DATA_W-1:0]);
      end else begin
        send_height(dir_tbl[i].value[15:0], n);
        if (dir_tbl[i].chk) begin
          for (int k = pending_slopes.size() - n; k < pending_slopes.size(); k++) begin
            if (pending_slopes[k].grad_x != dir_tbl[i].gx) begin
              $error("table row %0d grad_x expected %0d actual %0d", i, dir_tbl[i].gx,
                     pending_slopes[k].grad_x);
              fails++;
            end
            if (pending_slopes[k].grad_y != dir_tbl[i].gy) begin
              $error("table row %0d grad_y expected %0d actual %0d", i, dir_tbl[i].gy,
                     pending_slopes[k].grad_y);
              fails++;
            end
            if (pending_slopes[k].slope_mag != dir_tbl[i].mag) begin
              $error("table row %0d slope_mag expected %0d actual %0d", i, dir_tbl[i].mag,
                     pending_slopes[k].slope_mag);
              fails++;
            end
          end
        end
      end
    end

    // widest grid and tallest frame, shrunk in the first row
    in_if.valid <= 1'b0;
    drain_results();
    idle_mode = 1'b1;
    write_reg(REG_GRID_COLUMNS, 16'hFFFF);
    write_reg(REG_GRID_ROWS, 16'hFFFF);
    write_reg(REG_INV_SPACING_X, 16'($urandom));
    write_reg(REG_INV_SPACING_Y, 16'($urandom));
    repeat (6) send_height(16'($urandom), n);
    in_if.valid <= 1'b0;
    drain_results();
    write_reg(REG_GRID_COLUMNS, 16'd6);
    write_reg(REG_GRID_ROWS, 16'd3);
    repeat (13) send_height(16'($urandom), n);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      in_if.valid <= 1'b0;
      drain_results();
      idle_mode = ($urandom_range(0, 3) != 0);
      if (sent == 0) begin
        cols_val = 8;
        rows_val = 5;
      end else begin
        cols_val = $urandom_range(0, 8);
        rows_val = $urandom_range(0, 5);
      end
      w_eff = (cols_val < 2) ? 2 : cols_val;
      h_eff = (rows_val < 2) ? 2 : rows_val;
      write_reg(REG_GRID_COLUMNS, {($urandom_range(0, 1) ? 5'h1F : 5'h00), 11'(cols_val)});
      write_reg(REG_GRID_ROWS, 16'(rows_val));
      case ($urandom_range(0, 3))
        0: write_reg(REG_INV_SPACING_X, 16'hFFFF);
        1: write_reg(REG_INV_SPACING_X, 16'd0);
        default: write_reg(REG_INV_SPACING_X, 16'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_INV_SPACING_Y, 16'hFFFF);
        1: write_reg(REG_INV_SPACING_Y, 16'd0);
        default: write_reg(REG_INV_SPACING_Y, 16'($urandom));
      endcase
      // long receiver hold-off while heights keep coming
      if (sent == 0) hold_cycles = 300;
      frames = $urandom_range(1, 2);
      repeat (frames) begin
        smooth = $urandom_range(0, 1);
        h = 16'($urandom);
        repeat (w_eff * h_eff) begin
          if (smooth) h = h + 16'($signed($urandom_range(0, 600)) - 300);
          else h = 16'($urandom);
          send_height(h, n);
          sent++;
        end
      end
    end

    in_if.valid <= 1'b0;
    drain_results();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
